>>> rtl/lpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types, codes and constants of the lidar packet decoder.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam logic [7:0]  HDR_LO   = 8'hAA;
  localparam logic [7:0]  HDR_HI   = 8'h55;
  localparam logic [15:0] HDR_WORD = 16'h55AA;

  localparam int TURN_Q6    = 23040;
  localparam int WRAP_HI_Q6 = 17280;
  localparam int WRAP_LO_Q6 = 5760;

  localparam int CORDIC_STEPS = 17;
  localparam int DIV_STEPS    = 23;   // quotient bits of (diff << 8) / (n - 1)
  localparam int IDX_W        = 7;    // sample index, 0 to 127

  // header byte positions
  localparam logic [3:0] HP_LO   = 4'd0;
  localparam logic [3:0] HP_HI   = 4'd1;
  localparam logic [3:0] HP_TYPE = 4'd2;
  localparam logic [3:0] HP_CNT  = 4'd3;
  localparam logic [3:0] HP_FLO  = 4'd4;
  localparam logic [3:0] HP_FHI  = 4'd5;
  localparam logic [3:0] HP_LLO  = 4'd6;
  localparam logic [3:0] HP_LHI  = 4'd7;
  localparam logic [3:0] HP_CLO  = 4'd8;
  localparam logic [3:0] HP_CHI  = 4'd9;

  typedef enum logic [3:0] {
    ST_HDR, ST_DIVI, ST_DIV, ST_DIVE, ST_SMP, ST_CHK, ST_ERR,
    ST_RD, ST_CINIT, ST_CORD, ST_WINIT, ST_WRAP, ST_EMIT
  } state_t;

  typedef struct packed {
    logic             take;      // input item accepted this cycle
    logic             smp;       // ... and it is a sample byte
    logic [3:0]       hpos;
    logic [7:0]       bpos;
    logic             div_init;
    logic             div_step;
    logic             div_done;
    logic             acc_clr;
    logic             acc_add;
    logic             rd;
    logic [IDX_W-1:0] k;
    logic             cinit;
    logic             cstep;
    logic [4:0]       ci;
    logic             winit;
    logic             wstep;
    logic             out_pt;
    logic             out_err;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic       byte_ok;
    logic       cks_ok;
    logic [7:0] count;
    logic       t_neg;
    logic       t_over;
    logic       out_free;
  } sts_t;

  // CORDIC step angles, 1/(64*4096) degree
  function automatic logic signed [27:0] step_angle(input logic [4:0] i);
    logic signed [27:0] v;
    case (i)
      5'd0:    v = 28'sd11796480;
      5'd1:    v = 28'sd6963869;
      5'd2:    v = 28'sd3679517;
      5'd3:    v = 28'sd1867780;
      5'd4:    v = 28'sd937515;
      5'd5:    v = 28'sd469214;
      5'd6:    v = 28'sd234664;
      5'd7:    v = 28'sd117339;
      5'd8:    v = 28'sd58671;
      5'd9:    v = 28'sd29335;
      5'd10:   v = 28'sd14668;
      5'd11:   v = 28'sd7334;
      5'd12:   v = 28'sd3667;
      5'd13:   v = 28'sd1833;
      5'd14:   v = 28'sd917;
      5'd15:   v = 28'sd458;
      5'd16:   v = 28'sd229;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/lpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready channels: raw byte input and decoded point output.
// ----------------------------------------------------------------------------
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_q2;
  logic [14:0] angle_q6;
  logic        ring_start;
  logic        status;
  logic        last_of_packet;
  modport source (output valid, output range_q2, output angle_q6, output ring_start,
                  output status, output last_of_packet, input ready);
  modport sink   (input valid, input range_q2, input angle_q6, input ring_start,
                  input status, input last_of_packet, output ready);
endinterface

>>> rtl/lidar_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_decoder
// Byte-serial decoder for AA 55 lidar scan packets, one point item per sample.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    data_byte[7:0]
//  out_ch   out  valid/ready    range_q2[15:0], angle_q6[14:0], ring_start,
//                               status, last_of_packet
//
//  In the header and sample states bytes are taken one per cycle. After the last
//  angle byte the input stalls while the interval divider runs (one bit/cycle).
//  After the last sample byte each point takes a store read, 17 CORDIC steps, a
//  wrap init and wrap steps that add or subtract turns, then the result load.
//  A result waits in the output register; a stalled sink holds the sequencer.
//  Synchronous active-low reset; the sample store has no reset.
// ----------------------------------------------------------------------------
module lidar_packet_decoder import lpd_pkg::*; #(
  parameter int MAX_SAMPLES      = 40,
  parameter int CORR_TABLE_DEPTH = 16384
) (
  input logic        clk,
  input logic        rst_n,
  lpd_in_if.sink     in_ch,
  lpd_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // control: header position, byte and sample counters, step counts
  lpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: fields, store, divider, CORDIC, wrap and result register
  lpd_dp #(
    .MAX_SAMPLES      (MAX_SAMPLES),
    .CORR_TABLE_DEPTH (CORR_TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_byte            (in_ch.data_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_range_q2       (out_ch.range_q2),
    .out_angle_q6       (out_ch.angle_q6),
    .out_ring_start     (out_ch.ring_start),
    .out_status         (out_ch.status),
    .out_last_of_packet (out_ch.last_of_packet)
  );

  assign in_ch.ready = in_ready;

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_pt || cmd.out_err) |-> sts.out_free)
    else $error("result loaded over a pending item");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_pt && cmd.out_err))
    else $error("point and error loaded together");

  a_err_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_err |=> (out_ch.valid && out_ch.status && out_ch.last_of_packet))
    else $error("error item not presented");

  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.cstep) |-> !in_ready)
    else $error("input taken while a unit iterates");

endmodule

>>> rtl/lpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_ctrl
// Sequencer: header parse, divider and CORDIC step counts, point and error emission.
// ----------------------------------------------------------------------------
module lpd_ctrl import lpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [3:0]       hpos_r, hpos_nxt;
  logic [7:0]       bpos_r, bpos_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [4:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
      hpos_r  <= HP_LO;
      bpos_r  <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hpos_r  <= hpos_nxt;
      bpos_r  <= bpos_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    hpos_nxt  = hpos_r;
    bpos_nxt  = bpos_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.hpos  = hpos_r;
    cmd.bpos  = bpos_r;
    cmd.k     = k_r;
    cmd.ci    = cnt_r;
    cmd.out_last = ({1'b0, k_r} + 8'd1) == sts.count;

    case (state_r)
      ST_HDR: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (!sts.byte_ok) begin
            hpos_nxt = HP_LO;
          end else if (hpos_r == HP_LHI) begin
            hpos_nxt  = HP_CLO;
            state_nxt = ST_DIVI;
          end else if (hpos_r == HP_CHI) begin
            hpos_nxt  = HP_LO;
            bpos_nxt  = '0;
            state_nxt = ST_SMP;
          end else begin
            hpos_nxt = hpos_r + 4'd1;
          end
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = ST_DIVE;
      end
      ST_DIVE: begin
        cmd.div_done = 1'b1;
        state_nxt    = ST_HDR;
      end
      ST_SMP: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          cmd.smp  = 1'b1;
          bpos_nxt = bpos_r + 8'd1;
          if ({1'b0, bpos_nxt} >= {sts.count, 1'b0}) state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        k_nxt = '0;
        if (sts.cks_ok) begin
          cmd.acc_clr = 1'b1;
          state_nxt   = ST_RD;
        end else begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.out_err = 1'b1;
          state_nxt   = ST_HDR;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.cinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cstep = 1'b1;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_WINIT;
      end
      ST_WINIT: begin
        cmd.winit = 1'b1;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wstep = 1'b1;
        if (!sts.t_neg && !sts.t_over) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_pt  = 1'b1;
          cmd.acc_add = 1'b1;
          k_nxt       = k_r + 1'b1;
          state_nxt   = cmd.out_last ? ST_HDR : ST_RD;
        end
      end
      default: state_nxt = ST_HDR;
    endcase
  end

endmodule

>>> rtl/lpd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_dp
// Datapath: header fields, sample store, interval divider, CORDIC, angle wrap.
// ----------------------------------------------------------------------------
module lpd_dp import lpd_pkg::*; #(
  parameter int MAX_SAMPLES      = 40,
  parameter int CORR_TABLE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_range_q2,
  output logic [14:0] out_angle_q6,
  output logic        out_ring_start,
  output logic        out_status,
  output logic        out_last_of_packet
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [13:0] A_MAX = 14'(CORR_TABLE_DEPTH - 1);
  localparam logic signed [33:0] TURN_T = 34'sd5898240;   // 23040 * 256

  // header fields
  logic        ring_r;
  logic [7:0]  count_r, lo_hold_r;
  logic [15:0] first_r, last_r, cks_exp_r, cks_run_r;
  logic [23:0] piv_r;
  logic        byte_ok;

  // sample store
  logic [15:0] mem [MAX_SAMPLES];
  logic [15:0] rd_q_r;

  // divider
  logic [22:0] quo_r;
  logic [5:0]  rem_r, dvs_r;
  logic        div_en_r;
  logic [6:0]  trial;

  // CORDIC and angle
  logic signed [31:0] x_r, y_r, xs, ys;
  logic signed [27:0] z_r, zabs;
  logic               zero_r;
  logic [13:0]        a_val;
  logic [15:0]        zq;
  logic signed [15:0] corr;
  logic [29:0]        acc_r;
  logic signed [33:0] t_r;
  logic [23:0]        iv_cur;

  logic       out_valid_r;
  logic [15:0] w;
  logic [14:0] fa, la, dwrap;

  assign w      = {in_byte, lo_hold_r};
  assign fa     = first_r[15:1];
  assign la     = last_r[15:1];
  assign dwrap  = 15'(16'(TURN_Q6) + {1'b0, la} - {1'b0, fa});
  assign iv_cur = (count_r < 8'd2) ? '0 : piv_r;
  assign trial  = {rem_r, quo_r[22]};

  // header byte checks
  always_comb begin
    case (cmd.hpos)
      HP_LO:   byte_ok = (in_byte == HDR_LO);
      HP_HI:   byte_ok = (in_byte == HDR_HI);
      HP_TYPE: byte_ok = (in_byte <= 8'd1);
      HP_CNT:  byte_ok = (in_byte != 8'd0) && (in_byte <= 8'(MAX_SAMPLES));
      HP_FLO:  byte_ok = in_byte[0];
      HP_LLO:  byte_ok = in_byte[0];
      default: byte_ok = 1'b1;
    endcase
  end

  assign sts.byte_ok  = byte_ok;
  assign sts.cks_ok   = (cks_run_r ^ {count_r, 7'b0, ring_r} ^ last_r) == cks_exp_r;
  assign sts.count    = count_r;
  assign sts.t_neg    = t_r[33];
  assign sts.t_over   = t_r > TURN_T;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r    <= 1'b0;
      count_r   <= '0;
      lo_hold_r <= '0;
      first_r   <= '0;
      last_r    <= '0;
      cks_exp_r <= '0;
      cks_run_r <= '0;
      piv_r     <= '0;
    end else begin
      if (cmd.take && !cmd.smp) begin
        case (cmd.hpos)
          HP_LO:   ;
          HP_HI:   cks_run_r <= HDR_WORD;
          HP_TYPE: ring_r <= in_byte[0];
          HP_CNT:  count_r <= in_byte;
          HP_FLO:  first_r <= {8'h00, in_byte};
          HP_FHI: begin
            first_r   <= {in_byte, first_r[7:0]};
            cks_run_r <= cks_run_r ^ {in_byte, first_r[7:0]};
          end
          HP_LLO:  last_r <= {8'h00, in_byte};
          HP_LHI:  last_r <= {in_byte, last_r[7:0]};
          HP_CLO:  cks_exp_r <= {8'h00, in_byte};
          default: cks_exp_r <= {in_byte, cks_exp_r[7:0]};
        endcase
      end
      if (cmd.take && cmd.smp) begin
        if (!cmd.bpos[0]) lo_hold_r <= in_byte;
        else              cks_run_r <= cks_run_r ^ w;
      end
      if (cmd.div_done && div_en_r) piv_r <= {1'b0, quo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cmd.smp && cmd.bpos[0]) mem[cmd.bpos[AW:1]] <= w;
    if (cmd.rd) rd_q_r <= mem[cmd.k[AW-1:0]];
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      dvs_r <= 6'(count_r - 8'd1);
      if (count_r >= 8'd2 && la >= fa) begin
        div_en_r <= 1'b1;
        quo_r    <= {la - fa, 8'h00};
      end else if (count_r >= 8'd2 && fa > 15'(WRAP_HI_Q6) && la < 15'(WRAP_LO_Q6)) begin
        div_en_r <= 1'b1;
        quo_r    <= {dwrap, 8'h00};
      end else begin
        div_en_r <= 1'b0;
        quo_r    <= '0;
      end
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= 6'(trial - {1'b0, dvs_r});
        quo_r <= {quo_r[21:0], 1'b1};
      end else begin
        rem_r <= trial[5:0];
        quo_r <= {quo_r[21:0], 1'b0};
      end
    end
  end

  // distance correction: CORDIC vectoring
  assign a_val = (rd_q_r[15:2] > A_MAX) ? A_MAX : rd_q_r[15:2];
  assign xs    = x_r >>> cmd.ci;
  assign ys    = y_r >>> cmd.ci;
  assign zabs  = z_r[27] ? -z_r : z_r;
  assign zq    = 16'(zabs >> 12);
  assign corr  = zero_r ? 16'sd0 : (z_r[27] ? -$signed(zq) : $signed(zq));

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      x_r    <= $signed(32'(a_val) * 32'd15530);
      y_r    <= 32'sd338554 - $signed(32'(a_val) * 32'd2180);
      z_r    <= '0;
      zero_r <= (a_val == 14'd0);
    end else if (cmd.cstep) begin
      if (!y_r[31]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + step_angle(cmd.ci);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - step_angle(cmd.ci);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr)      acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_r + {6'b0, iv_cur};
    if (cmd.winit) begin
      t_r <= $signed({11'b0, fa, 8'b0}) + $signed({4'b0, acc_r})
           + $signed({{10{corr[15]}}, corr, 8'b0});
    end else if (cmd.wstep) begin
      if (t_r[33])          t_r <= t_r + TURN_T;
      else if (t_r > TURN_T) t_r <= t_r - TURN_T;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_pt || cmd.out_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_pt) begin
      out_range_q2       <= rd_q_r;
      out_angle_q6       <= t_r[22:8];
      out_ring_start     <= ring_r;
      out_status         <= 1'b0;
      out_last_of_packet <= cmd.out_last;
    end else if (cmd.out_err) begin
      out_range_q2       <= '0;
      out_angle_q6       <= '0;
      out_ring_start     <= 1'b0;
      out_status         <= 1'b1;
      out_last_of_packet <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> test/lidar_packet_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_decoder_tb
// Self-checking bench: byte streams of AA 55 scan packets (good, corrupted,
// truncated and plain noise) go in with random gaps; every point item out is
// compared against a local packet decoder with its own CORDIC correction.
// ----------------------------------------------------------------------------
module lidar_packet_decoder_tb;
  import lpd_pkg::*;

  localparam int NSMP     = 40;
  localparam int WD_LIMIT = 5000;   // idle cycles before we give up
  localparam int TAIL     = 200;    // settle time after the last point

  // step angles in 1/(64*4096) degree
  localparam longint STEP_TBL [CORDIC_STEPS] = '{
    11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229
  };

  typedef struct packed {
    logic [15:0] rng;
    logic [14:0] ang;
    logic        ring;
    logic        stat;
    logic        last;
  } point_t;

  logic clk;
  logic rst_n;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  lidar_packet_decoder #(.MAX_SAMPLES(NSMP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // --------------------------------------------------------------------------
  // decoder state mirror
  // --------------------------------------------------------------------------
  logic [3:0]  hdr_pos;
  logic        in_body;
  logic        ring_q;
  logic [7:0]  cnt_q;
  logic [15:0] first_w, last_w;
  logic [15:0] cks_want, cks_run;
  logic [23:0] ivl_q;
  logic [7:0]  lo_hold;
  logic [7:0]  body_pos;
  logic [15:0] dist_store [NSMP];

  point_t points_due [$];

  int unsigned n_bytes, n_points, n_bad;
  int unsigned idle_cnt;
  bit          rx_calm, tx_calm;
  int unsigned rx_hold;             // one-off long hold-off request

  // distance correction, 1/64 degree
  function automatic longint corr_q6(input logic [15:0] d);
    longint a, x, y, z, nx, ny;
    a = d >> 2;
    if (a > 16383) a = 16383;
    if (a == 0) return 0;
    x = 15530 * a;
    y = 218 * (1553 - 10 * a);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += STEP_TBL[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= STEP_TBL[i];
      end
      x = nx;
      y = ny;
    end
    return z / 4096;   // truncates toward zero
  endfunction

  // interval update on the last angle byte
  task automatic update_interval();
    logic [31:0] f, l;
    f = first_w >> 1;
    l = last_w >> 1;
    if (cnt_q < 2) return;
    if (l >= f)
      ivl_q = 24'(((l - f) * 256) / (cnt_q - 1));
    else if (f > WRAP_HI_Q6 && l < WRAP_LO_Q6)
      ivl_q = 24'(((TURN_Q6 + l - f) * 256) / (cnt_q - 1));
  endtask

  task automatic close_packet();
    logic [15:0] cal;
    longint      t, turn, iv;
    point_t      p;
    cal = cks_run ^ {cnt_q, 7'd0, ring_q} ^ last_w;
    turn = longint'(TURN_Q6) * 256;
    iv = (cnt_q < 2) ? 0 : ivl_q;
    in_body = 0;
    hdr_pos = HP_LO;
    if (cal != cks_want) begin
      p = '{rng: '0, ang: '0, ring: 1'b0, stat: 1'b1, last: 1'b1};
      points_due.push_back(p);
      return;
    end
    for (int k = 0; k < cnt_q && k < NSMP; k++) begin
      t = longint'(first_w >> 1) * 256 + iv * k + corr_q6(dist_store[k]) * 256;
      if (t < 0) t += turn;
      while (t > turn) t -= turn;
      p.rng  = dist_store[k];
      p.ang  = 15'(t >> 8);
      p.ring = ring_q;
      p.stat = 1'b0;
      p.last = (k + 1 == cnt_q);
      points_due.push_back(p);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    bit ok;
    logic [15:0] w;
    if (in_body) begin
      if (!body_pos[0]) lo_hold = b;
      else begin
        w = {b, lo_hold};
        cks_run ^= w;
        if ((body_pos >> 1) < NSMP) dist_store[body_pos >> 1] = w;
      end
      body_pos = body_pos + 8'd1;
      if (body_pos >= 2 * cnt_q) close_packet();
      return;
    end
    ok = 1;
    case (hdr_pos)
      HP_LO:   ok = (b == HDR_LO);
      HP_HI: begin
        ok = (b == HDR_HI);
        cks_run = HDR_WORD;
      end
      HP_TYPE: begin
        ok = (b <= 1);
        ring_q = b[0];
      end
      HP_CNT: begin
        ok = (b != 0 && b <= NSMP);
        cnt_q = b;
      end
      HP_FLO: begin
        ok = b[0];
        first_w = {8'd0, b};
      end
      HP_FHI: begin
        first_w[15:8] = b;
        cks_run ^= first_w;
      end
      HP_LLO: begin
        ok = b[0];
        last_w = {8'd0, b};
      end
      HP_LHI: begin
        last_w[15:8] = b;
        update_interval();
      end
      HP_CLO:  cks_want = {8'd0, b};
      default: cks_want[15:8] = b;
    endcase
    if (!ok) hdr_pos = HP_LO;
    else if (hdr_pos >= HP_CHI) begin
      hdr_pos = HP_LO;
      in_body = 1;
      body_pos = 0;
    end else hdr_pos++;
  endtask

  // --------------------------------------------------------------------------
  // clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WD_LIMIT) begin
      $display("lidar_packet_decoder: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stall per item, optional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned w;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        w = rx_hold;
        rx_hold = 0;
      end else w = rx_calm ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_ch.ready = 0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready = 1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // point checker
  always @(posedge clk) begin
    point_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{rng: out_ch.range_q2, ang: out_ch.angle_q6, ring: out_ch.ring_start,
              stat: out_ch.status, last: out_ch.last_of_packet};
      n_points++;
      if (points_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected point item %p", got);
      end else begin
        want = points_due.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) $display("point %0d: expected %p, got %p", n_points, want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // byte side
  // --------------------------------------------------------------------------
  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b);
    n_bytes++;
    @(negedge clk);
  endtask

  // wait for every point, then let the sequencer settle
  task automatic drain();
    in_ch.valid = 0;
    while (points_due.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  // trunc > 0 cuts the packet after that many header bytes, then sends one random byte
  task automatic send_packet(input logic ring, input logic [7:0] n,
                             input logic [15:0] fr, input logic [15:0] lr,
                             input bit bad_cks, input int trunc = 0);
    logic [7:0]  hb [10];
    logic [15:0] cks, d;
    logic [15:0] dl [$];
    cks = HDR_WORD ^ fr ^ lr ^ {n, 7'd0, ring};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       d = 16'($urandom_range(0, 40));
        1:       d = 16'($urandom_range(0, 1000));
        default: d = 16'($urandom);
      endcase
      dl.push_back(d);
      cks ^= d;
    end
    if (bad_cks) cks ^= 16'(1 << $urandom_range(0, 15));
    hb = '{HDR_LO, HDR_HI, {7'd0, ring}, n, fr[7:0], fr[15:8], lr[7:0], lr[15:8],
           cks[7:0], cks[15:8]};
    for (int i = 0; i < 10; i++) begin
      if (trunc > 0 && i == trunc) begin
        send_byte(8'($urandom));
        return;
      end
      send_byte(hb[i]);
    end
    foreach (dl[i]) begin
      send_byte(dl[i][7:0]);
      send_byte(dl[i][15:8]);
    end
  endtask

  function automatic logic [15:0] raw_angle(input int q6);
    return {q6[14:0], 1'b1};
  endfunction

  // random packet, consecutive angles except one time in eight (random raw angles)
  task automatic send_random_packet(input int max_n, input bit bad_cks);
    int n, f, span;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NSMP) : $urandom_range(1, max_n);
    f = $urandom_range(0, TURN_Q6 - 1);
    span = $urandom_range(0, 2000);
    if ($urandom_range(0, 7) == 0)
      send_packet(1'($urandom_range(0, 1)), 8'(n), 16'($urandom | 1), 16'($urandom | 1),
                  bad_cks);
    else
      send_packet(1'($urandom_range(0, 1)), 8'(n), raw_angle(f),
                  raw_angle((f + span) % TURN_Q6), bad_cks);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_LO);
    send_byte(HDR_LO);     // rejected, not a fresh start
    send_byte(HDR_HI);
    send_byte(HDR_LO);
    send_byte(HDR_HI);
    send_byte(8'd2);       // type out of range
    send_packet(0, 0, 16'h0001, 16'h0001, 0, 4);          // zero count
    send_packet(0, NSMP + 1, 16'h0001, 16'h0001, 0, 4);   // count too big
    send_packet(0, 8'd3, 16'h0010, 16'h0101, 0, 5);       // first check bit clear
    send_packet(0, 8'd3, 16'h0011, 16'h0100, 0, 7);       // last check bit clear
    drain();
  endtask

  task automatic test_edge_packets();
    send_packet(1, 8'd1, 16'hFFFF, 16'hFFFF, 0);             // one sample, top angle
    send_packet(0, 8'd2, raw_angle(0), raw_angle(1000), 0);
    send_packet(1, 8'd4, raw_angle(22000), raw_angle(300), 0); // wraps through zero
    send_packet(0, 8'd4, raw_angle(9000), raw_angle(4000), 0); // reuses last interval
    send_packet(0, 8'd3, raw_angle(100), raw_angle(400), 1);   // checksum error
    send_packet(1, NSMP, raw_angle(23000), raw_angle(23039), 0);
    send_packet(0, 8'd2, 16'h0001, 16'hFFFF, 0);
    drain();
  endtask

  task automatic test_random_stream();
    int pick;
    do begin
      tx_calm = ($urandom_range(0, 7) == 0);
      rx_calm = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 13)      send_random_packet(6, 0);
      else if (pick < 15) send_random_packet(6, 1);
      else if (pick < 17) send_packet(0, 8'd3, raw_angle(50), raw_angle(90), 0,
                                      $urandom_range(1, 9));
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end while (n_bytes < 320);
    tx_calm = 0;
    rx_calm = 0;
    drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 400;
    tx_calm = 1;
    send_random_packet(2, 0);
    send_packet(0, 8'd8, raw_angle(500), raw_angle(5000), 0);
    send_packet(1, 8'd5, raw_angle(7000), raw_angle(7500), 0);
    tx_calm = 0;
    drain();
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.data_byte = '0;
    hdr_pos = HP_LO;
    in_body = 0;
    ring_q = 0;
    cnt_q = 0;
    first_w = 0;
    last_w = 0;
    cks_want = 0;
    cks_run = 0;
    ivl_q = 0;
    lo_hold = 0;
    body_pos = 0;
    foreach (dist_store[i]) dist_store[i] = 0;
    n_bytes = 0;
    n_points = 0;
    n_bad = 0;
    idle_cnt = 0;
    rx_calm = 0;
    tx_calm = 0;
    rx_hold = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    test_header_hunt();
    test_edge_packets();
    test_backpressure();
    test_random_stream();

    if (n_bad == 0 && points_due.size() == 0) begin
      $display("lidar_packet_decoder: match");
    end else begin
      $display("lidar_packet_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lpd_pkg.sv
rtl/lpd_if.sv
rtl/lpd_ctrl.sv
rtl/lpd_dp.sv
rtl/lidar_packet_decoder.sv
test/lidar_packet_decoder_tb.sv
